>>> src/round_robin_thread_list_assert.svh
// Assertion macros for the round-robin thread list RTL.
// Expects clk_i and rst_ni in the scope of use.
`ifndef ROUND_ROBIN_THREAD_LIST_ASSERT_SVH
`define ROUND_ROBIN_THREAD_LIST_ASSERT_SVH

// Property holds at every clock edge out of reset.
`define RRTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define RRTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rrtl_pkg.sv
// Package for the round-robin thread list: command and status codes,
// cell operation codes and the broadcast control struct. No dependencies.
package rrtl_pkg;

  // Width of index and count fields in the cell control (covers up to 511 entries).
  localparam int CNT_W = 9;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_QUERY  = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_SWITCH = 3'd3;
  localparam logic [2:0] CMD_REMCUR = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_CURRENT = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_SHL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] cnt;
  } cell_ctrl_t;

endpackage

>>> src/rrtl_cell.sv
// One entry of the rotated thread list; trades its id with its neighbors.
// Depends on rrtl_pkg.
module rrtl_cell #(
  parameter int ID_BITS = 8,
  parameter int IDX     = 0
) (
  input  logic                clk_i,
  input  rrtl_pkg::cell_ctrl_t ctrl_i,
  input  logic [ID_BITS-1:0]  new_id_i,
  input  logic [ID_BITS-1:0]  left_i,
  input  logic [ID_BITS-1:0]  right_i,
  input  logic [ID_BITS-1:0]  head_i,
  input  logic [ID_BITS-1:0]  key_i,
  output logic [ID_BITS-1:0]  id_o,
  output logic                match_o
);

  localparam logic [rrtl_pkg::CNT_W-1:0] Here = rrtl_pkg::CNT_W'(IDX);

  logic [ID_BITS-1:0] id_q, id_d;

  always_comb begin
    id_d = id_q;
    case (ctrl_i.op)
      rrtl_pkg::CELL_INS: begin
        if (Here == ctrl_i.k) begin
          id_d = new_id_i;
        end else if (Here > ctrl_i.k) begin
          id_d = left_i;
        end
      end
      rrtl_pkg::CELL_SHL: begin
        if (Here >= ctrl_i.k) begin
          id_d = right_i;
        end
      end
      rrtl_pkg::CELL_ROT: begin
        if (Here < ctrl_i.k) begin
          id_d = right_i;
        end else if (Here == ctrl_i.k) begin
          id_d = head_i;
        end
      end
      default: id_d = id_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o    = id_q;
  assign match_o = (Here < ctrl_i.cnt) && (id_q == key_i);

endmodule

>>> src/round_robin_thread_list.sv
// Round-robin thread list. A request (start high, busy low) is captured, then goes
// through the parallel search across the cells, the cell update and the result
// state; busy stays high until a one-cycle done_o pulse brings all result fields,
// so no request is taken before then. The receiver cannot stall: done_o and the result
// fields hold for that one cycle only and must be taken as they come.
// The list is kept rotated so the current thread
// always sits in cell 0; every update is a single shift across the cell row.
// Depends on rrtl_pkg, rrtl_cell and round_robin_thread_list_assert.svh.
module round_robin_thread_list #(
  parameter int MAX_THREADS = 16,
  parameter int ID_BITS     = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] cmd_i,
  input  logic [7:0] thread_id_i,
  output logic       done_o,
  output logic [2:0] status_o,
  output logic       present_o,
  output logic [7:0] previous_thread_o,
  output logic [7:0] current_thread_o,
  output logic       context_switch_o,
  output logic [4:0] thread_count_o
);

  localparam int IW  = $clog2(MAX_THREADS);
  localparam int CLW = $clog2(MAX_THREADS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SRCH   = 4'b0010,
    S_APPLY  = 4'b0100,
    S_REPORT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]         cmd_q;
  logic [ID_BITS-1:0] key_q;
  logic [CLW-1:0]     n_q, n_d;
  logic [IW-1:0]      pos_q, pos_d;
  logic [IW-1:0]      r_q, r_d;
  logic               present_q, had_q, done_q, ctx_q;
  logic [ID_BITS-1:0] prev_q, cur_id;
  logic [2:0]         status_q, status_d;
  logic [7:0]         current_q;
  logic [4:0]         count_q;

  logic [ID_BITS-1:0] cell_id [MAX_THREADS];
  logic [MAX_THREADS-1:0] match;
  rrtl_pkg::cell_ctrl_t ctrl;
  rrtl_pkg::cell_op_e   op_d;
  logic [CLW-1:0]       k_d;

  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
    logic [ID_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_id[i-1];
    end
    if (i == MAX_THREADS - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_id[i+1];
    end
    rrtl_cell #(.ID_BITS(ID_BITS), .IDX(i)) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .new_id_i (key_q),
      .left_i   (left),
      .right_i  (right),
      .head_i   (cell_id[0]),
      .key_i    (key_q),
      .id_o     (cell_id[i]),
      .match_o  (match[i])
    );
  end

  // ids in the list are distinct, so at most one match bit is set
  always_comb begin
    r_d = '0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (match[i]) begin
        r_d = r_d | IW'(i);
      end
    end
  end

  assign cur_id = (n_q != '0) ? cell_id[0] : '0;

  always_comb begin
    logic [CLW-1:0] pos_x, r_x, ins_x;
    pos_x    = CLW'(pos_q);
    r_x      = CLW'(r_q);
    ins_x    = n_q - pos_x;
    status_d = rrtl_pkg::ST_OK;
    n_d      = n_q;
    pos_d    = pos_q;
    op_d     = rrtl_pkg::CELL_HOLD;
    k_d      = '0;
    case (cmd_q)
      rrtl_pkg::CMD_ADD: begin
        if (present_q) begin
          status_d = rrtl_pkg::ST_PRESENT;
        end else if (n_q >= CLW'(MAX_THREADS)) begin
          status_d = rrtl_pkg::ST_FULL;
        end else begin
          op_d = rrtl_pkg::CELL_INS;
          k_d  = ins_x;
          n_d  = n_q + 1'b1;
        end
      end
      rrtl_pkg::CMD_QUERY: begin
        status_d = present_q ? rrtl_pkg::ST_OK : rrtl_pkg::ST_ABSENT;
      end
      rrtl_pkg::CMD_REMOVE: begin
        if (n_q == '0) begin
          status_d = rrtl_pkg::ST_EMPTY;
        end else if (!present_q) begin
          status_d = rrtl_pkg::ST_ABSENT;
        end else if (r_q == '0) begin
          status_d = rrtl_pkg::ST_CURRENT;
        end else begin
          op_d = rrtl_pkg::CELL_SHL;
          k_d  = r_x;
          n_d  = n_q - 1'b1;
          // entry lay before the current one in list order
          if (r_x >= ins_x) begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      rrtl_pkg::CMD_SWITCH: begin
        if (n_q == '0) begin
          status_d = rrtl_pkg::ST_EMPTY;
        end else begin
          op_d  = rrtl_pkg::CELL_ROT;
          k_d   = n_q - 1'b1;
          pos_d = (pos_x + 1'b1 >= n_q) ? '0 : pos_q + 1'b1;
        end
      end
      rrtl_pkg::CMD_REMCUR: begin
        if (n_q == '0) begin
          status_d = rrtl_pkg::ST_EMPTY;
        end else if (n_q == CLW'(1)) begin
          n_d   = '0;
          pos_d = '0;
        end else begin
          op_d  = rrtl_pkg::CELL_SHL;
          k_d   = '0;
          n_d   = n_q - 1'b1;
          pos_d = (pos_x + 1'b1 >= n_q) ? '0 : pos_q;
        end
      end
      default: status_d = rrtl_pkg::ST_OK;
    endcase
  end

  always_comb begin
    ctrl.op  = (state_q == S_APPLY) ? op_d : rrtl_pkg::CELL_HOLD;
    ctrl.k   = rrtl_pkg::CNT_W'(k_d);
    ctrl.cnt = rrtl_pkg::CNT_W'(n_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start) state_d = S_SRCH;
      S_SRCH:   state_d = S_APPLY;
      S_APPLY:  state_d = S_REPORT;
      S_REPORT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      pos_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_REPORT);
      if (state_q == S_APPLY) begin
        n_q   <= n_d;
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      cmd_q <= cmd_i;
      key_q <= ID_BITS'(thread_id_i);
    end
    if (state_q == S_SRCH) begin
      r_q       <= r_d;
      present_q <= |match;
      had_q     <= (n_q != '0);
      prev_q    <= cur_id;
    end
    if (state_q == S_APPLY) begin
      status_q <= status_d;
    end
    if (state_q == S_REPORT) begin
      current_q <= 8'(cur_id);
      ctx_q     <= had_q && (n_q != '0) && (prev_q != cur_id);
      count_q   <= 5'(n_q);
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign present_o         = present_q;
  assign previous_thread_o = 8'(prev_q);
  assign current_thread_o  = current_q;
  assign context_switch_o  = ctx_q;
  assign thread_count_o    = count_q;

`include "round_robin_thread_list_assert.svh"

  `RRTL_ASSERT(a_count_max, n_q <= CLW'(MAX_THREADS), "thread count above capacity")
  `RRTL_ASSERT(a_pos_range, (pos_q == '0) || (CLW'(pos_q) < n_q), "current position out of list")
  `RRTL_ASSERT_NEXT(a_done_src, state_q == S_REPORT, done_o && !busy, "result not reported")
  `RRTL_ASSERT_NEXT(a_count_step, state_q == S_APPLY, (n_q == $past(n_q)) || (n_q == $past(n_q) + 1'b1) || (n_q + 1'b1 == $past(n_q)), "count moved by more than one")

endmodule

>>> tb/round_robin_thread_list_tb.sv
// Self-checking testbench for round_robin_thread_list: directed and random requests
// are checked against a scoreboard that tracks the ready list.
// Depends on rrtl_pkg and the round_robin_thread_list RTL.
module round_robin_thread_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_THREADS     = 16;
  localparam int TARGET_REQUESTS = 1950;
  localparam int PHASE_REQUESTS  = 150;
  localparam int POOL_SIZE       = 24;
  localparam int REPORT_LIMIT    = 10;
  localparam int SETTLE_CYCLES   = 8;

  // Codes the block does not decode.
  localparam logic [2:0] CMD_UNDEF_A = 3'd5;
  localparam logic [2:0] CMD_UNDEF_B = 3'd6;
  localparam logic [2:0] CMD_UNDEF_C = 3'd7;

  typedef struct packed {
    logic [2:0] status;
    logic       present;
    logic [7:0] previous_thread;
    logic [7:0] current_thread;
    logic       context_switch;
    logic [4:0] thread_count;
  } sched_result_t;

  class ready_list_scoreboard;
    logic [7:0]    entries [MAX_THREADS];
    int unsigned   depth;
    int unsigned   position;
    sched_result_t pending_results [$];
    int unsigned   failures;
    int unsigned   results_seen;
    int unsigned   peak_depth;
    int unsigned   ctx_switches;
    int unsigned   full_refusals;
    int unsigned   empty_refusals;

    function logic [7:0] current_id();
      return (depth == 0) ? 8'h00 : entries[position];
    endfunction

    function int unsigned locate(logic [7:0] id);
      for (int unsigned i = 0; i < depth; i++) begin
        if (entries[i] == id) return i;
      end
      return depth;
    endfunction

    function void drop_entry(int unsigned idx);
      for (int unsigned i = idx; i + 1 < depth; i++) entries[i] = entries[i + 1];
      depth--;
    endfunction

    function logic [7:0] pick_listed_id();
      if (depth == 0) return 8'($urandom);
      return entries[$urandom_range(0, depth - 1)];
    endfunction

    function void note_request(logic [2:0] op, logic [7:0] id);
      sched_result_t r;
      int unsigned   idx;
      bit            had_current;
      int unsigned   old_pos;
      bit            wraps;
      idx               = locate(id);
      had_current       = depth != 0;
      r.status          = rrtl_pkg::ST_OK;
      r.present         = idx < depth;
      r.previous_thread = current_id();
      case (op)
        rrtl_pkg::CMD_ADD: begin
          if (r.present) r.status = rrtl_pkg::ST_PRESENT;
          else if (depth >= MAX_THREADS) r.status = rrtl_pkg::ST_FULL;
          else begin
            entries[depth] = id;
            depth++;
            if (depth == 1) position = 0;
          end
        end
        rrtl_pkg::CMD_QUERY: begin
          if (!r.present) r.status = rrtl_pkg::ST_ABSENT;
        end
        rrtl_pkg::CMD_REMOVE: begin
          if (depth == 0) r.status = rrtl_pkg::ST_EMPTY;
          else if (!r.present) r.status = rrtl_pkg::ST_ABSENT;
          else if (idx == position) r.status = rrtl_pkg::ST_CURRENT;
          else begin
            drop_entry(idx);
            if (idx < position) position--;
          end
        end
        rrtl_pkg::CMD_SWITCH: begin
          if (depth == 0) r.status = rrtl_pkg::ST_EMPTY;
          else position = (position + 1 >= depth) ? 0 : position + 1;
        end
        rrtl_pkg::CMD_REMCUR: begin
          if (depth == 0) r.status = rrtl_pkg::ST_EMPTY;
          else if (depth == 1) begin
            depth    = 0;
            position = 0;
          end else begin
            old_pos = position;
            wraps   = old_pos + 1 >= depth;
            drop_entry(old_pos);
            position = wraps ? 0 : old_pos;
          end
        end
        default: ;
      endcase
      r.current_thread = current_id();
      r.context_switch = had_current && depth != 0 && r.previous_thread != r.current_thread;
      r.thread_count   = 5'(depth);
      if (depth > peak_depth) peak_depth = depth;
      if (r.context_switch) ctx_switches++;
      if (r.status == rrtl_pkg::ST_FULL) full_refusals++;
      if (r.status == rrtl_pkg::ST_EMPTY) empty_refusals++;
      pending_results = {pending_results, r};
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("mismatch %0d at %0t: %s", failures, $time, msg);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        flag($sformatf("result with no request outstanding: %p", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.present !== want.present ||
          got.previous_thread !== want.previous_thread ||
          got.current_thread !== want.current_thread ||
          got.context_switch !== want.context_switch ||
          got.thread_count !== want.thread_count) begin
        flag($sformatf({"status %0d/%0d present %0b/%0b prev %02h/%02h cur %02h/%02h ",
                        "ctx %0b/%0b count %0d/%0d (expected/actual)"},
                       want.status, got.status, want.present, got.present,
                       want.previous_thread, got.previous_thread,
                       want.current_thread, got.current_thread,
                       want.context_switch, got.context_switch,
                       want.thread_count, got.thread_count));
      end
    endfunction

    function void close_out();
      if (pending_results.size() != 0)
        flag($sformatf("%0d results never arrived", pending_results.size()));
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic       busy;
  logic [2:0] cmd_i       = rrtl_pkg::CMD_ADD;
  logic [7:0] thread_id_i = 8'h00;
  logic       done_o;
  logic [2:0] status_o;
  logic       present_o;
  logic [7:0] previous_thread_o;
  logic [7:0] current_thread_o;
  logic       context_switch_o;
  logic [4:0] thread_count_o;

  ready_list_scoreboard sb = new();

  round_robin_thread_list #(
    .MAX_THREADS(MAX_THREADS),
    .ID_BITS    (8)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .thread_id_i      (thread_id_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .present_o        (present_o),
    .previous_thread_o(previous_thread_o),
    .current_thread_o (current_thread_o),
    .context_switch_o (context_switch_o),
    .thread_count_o   (thread_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      sb.check_result({status_o, present_o, previous_thread_o, current_thread_o,
                       context_switch_o, thread_count_o});
    end
  end

  task automatic send_request(input logic [2:0] op, input logic [7:0] id);
    start       <= 1'b1;
    cmd_i       <= op;
    thread_id_i <= id;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(op, id);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  function automatic logic [2:0] pick_op(int add_weight);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      case ($urandom_range(0, 2))
        0:       return CMD_UNDEF_A;
        1:       return CMD_UNDEF_B;
        default: return CMD_UNDEF_C;
      endcase
    end
    if (roll - 3 < add_weight) return rrtl_pkg::CMD_ADD;
    roll = $urandom_range(0, 99);
    if (roll < 25) return rrtl_pkg::CMD_QUERY;
    if (roll < 60) return rrtl_pkg::CMD_REMOVE;
    if (roll < 85) return rrtl_pkg::CMD_SWITCH;
    return rrtl_pkg::CMD_REMCUR;
  endfunction

  initial begin
    logic [7:0]  pool [POOL_SIZE];
    logic [2:0]  op;
    logic [7:0]  id;
    int          counted;
    int          reserved;
    int          phase_end;
    int          add_weight;
    int          roll;
    bit          quiet;
    counted  = 0;
    reserved = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list, single entry, refusals, wrap and removal corners.
    send_request(rrtl_pkg::CMD_QUERY,  8'h00);
    send_request(rrtl_pkg::CMD_REMOVE, 8'h5A);
    send_request(rrtl_pkg::CMD_SWITCH, 8'hFF);
    send_request(rrtl_pkg::CMD_REMCUR, 8'hFF);
    send_request(CMD_UNDEF_C,          8'hFF);
    send_request(rrtl_pkg::CMD_ADD,    8'h00);
    send_request(rrtl_pkg::CMD_ADD,    8'h00);
    send_request(rrtl_pkg::CMD_SWITCH, 8'h00);
    send_request(rrtl_pkg::CMD_QUERY,  8'h00);
    send_request(rrtl_pkg::CMD_ADD,    8'hFF);
    send_request(rrtl_pkg::CMD_ADD,    8'h81);
    send_request(rrtl_pkg::CMD_QUERY,  8'h7E);
    send_request(rrtl_pkg::CMD_REMOVE, 8'h00);
    send_request(rrtl_pkg::CMD_REMOVE, 8'h7E);
    send_request(rrtl_pkg::CMD_SWITCH, 8'h00);
    send_request(rrtl_pkg::CMD_REMOVE, 8'h00);
    send_request(CMD_UNDEF_A,          8'h81);
    send_request(CMD_UNDEF_B,          8'h00);
    send_request(rrtl_pkg::CMD_SWITCH, 8'hFF);
    send_request(rrtl_pkg::CMD_REMCUR, 8'h00);
    send_request(rrtl_pkg::CMD_REMCUR, 8'h00);
    send_request(rrtl_pkg::CMD_ADD,    8'h3C);
    send_request(rrtl_pkg::CMD_REMOVE, 8'h3C);
    counted += 20;
    reserved += 3;
    wait_idle();

    while (counted < TARGET_REQUESTS) begin
      foreach (pool[i]) pool[i] = 8'($urandom);
      case ($urandom_range(0, 2))
        0:       add_weight = 55;
        1:       add_weight = 30;
        default: add_weight = 15;
      endcase
      quiet     = (counted >= TARGET_REQUESTS - PHASE_REQUESTS) || ($urandom_range(0, 2) == 0);
      phase_end = counted + PHASE_REQUESTS;
      while (counted < phase_end && counted < TARGET_REQUESTS) begin
        op   = pick_op(add_weight);
        roll = $urandom_range(0, 99);
        if (roll < 10) id = 8'($urandom);
        else if ((op == rrtl_pkg::CMD_REMOVE || op == rrtl_pkg::CMD_QUERY) && roll < 60)
          id = sb.pick_listed_id();
        else id = pool[$urandom_range(0, POOL_SIZE - 1)];
        send_request(op, id);
        if (op > rrtl_pkg::CMD_REMCUR) reserved++;
        else counted++;
        if (!quiet && $urandom_range(0, 99) < 30) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
        end
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.close_out();
    $display("Ran %0d requests plus %0d undecoded codes, %0d results checked.",
             counted, reserved, sb.results_seen);
    $display("Peak depth %0d of %0d, %0d full and %0d empty refusals, %0d context switches.",
             sb.peak_depth, MAX_THREADS, sb.full_refusals, sb.empty_refusals,
             sb.ctx_switches);
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/rrtl_pkg.sv
src/rrtl_cell.sv
src/round_robin_thread_list.sv
tb/round_robin_thread_list_tb.sv
